/* src/pspm_pkg.sv */
// Package with shared types, constants and configuration indexes for the pedal mapper.
`timescale 1ns / 1ps
package pspm_pkg;

	localparam int ADC_BITS_DEF = 12;
	localparam int PER_MILLE    = 1000;
	localparam int PERCENT      = 100;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ADC_FULL_SCALE    = 3'd0,
		REG_ACCEL_ERROR_LIMIT = 3'd1,
		REG_ACCEL_MIN         = 3'd2,
		REG_ACCEL_MAX         = 3'd3,
		REG_BRAKE_HALL_MIN    = 3'd4,
		REG_BRAKE_HALL_MAX    = 3'd5,
		REG_BRAKE_ERROR_LIMIT = 3'd6
	} cfg_reg_t;

	// Handshake controls between the pipeline stages.
	typedef struct packed {
		logic valid;
		logic advance;
	} stage_ctl_t;

endpackage

/* src/pspm_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module pspm_div
	import pspm_pkg::*;
#(
	parameter int NUM_W = 22,
	parameter int DEN_W = 12
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	logic [NUM_W-1:0] rem_s [NUM_W+1];
	logic [NUM_W-1:0] q_s   [NUM_W+1];
	logic [DEN_W-1:0] d_s   [NUM_W+1];

	assign rem_s[0] = num;
	assign q_s[0]   = '0;
	assign d_s[0]   = den;

	for (genvar k = 0; k < NUM_W; k++) begin : g_bit
		localparam int SH = NUM_W - 1 - k;
		logic [NUM_W+DEN_W-1:0] dsh;
		logic                   ge;
		logic [NUM_W-1:0]       rem_q, qq;
		logic [DEN_W-1:0]       dq;
		assign dsh = {{NUM_W{1'b0}}, d_s[k]} << SH;
		assign ge  = {{DEN_W{1'b0}}, rem_s[k]} >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q <= ge ? rem_s[k] - dsh[NUM_W-1:0] : rem_s[k];
				qq    <= q_s[k] | (NUM_W'(ge) << SH);
				dq    <= d_s[k];
			end
		end
		assign rem_s[k+1] = rem_q;
		assign q_s[k+1]   = qq;
		assign d_s[k+1]   = dq;
	end

	assign quo = q_s[NUM_W];

endmodule

/* src/pspm_cfg.sv */
// Configuration register file.
`timescale 1ns / 1ps
module pspm_cfg
	import pspm_pkg::*;
#(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [ADC_BITS-1:0]   fs,
	output logic [7:0]            accel_lim,
	output logic [ADC_BITS-1:0]   accel_min,
	output logic [ADC_BITS-1:0]   accel_max,
	output logic [ADC_BITS-1:0]   hall_min,
	output logic [ADC_BITS-1:0]   hall_max,
	output logic [7:0]            brake_lim
);

	localparam logic [ADC_BITS-1:0] ALL1 = '1;
	logic [ADC_BITS-1:0] fs_q, amin_q, amax_q, hmin_q, hmax_q;
	logic [7:0]          alim_q, blim_q;
	logic [ADC_BITS-1:0] w;

	// Data is 12 bits; wider converters see zero-extended values.
	always_comb begin
		w = '0;
		for (int i = 0; i < ADC_BITS && i < CFG_DATA_W; i++) w[i] = cfg_data[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q   <= ALL1 & ADC_BITS'(4095);
			alim_q <= 8'd100;
			amin_q <= '0;
			amax_q <= ALL1 & ADC_BITS'(4095);
			hmin_q <= '0;
			hmax_q <= ALL1 & ADC_BITS'(4095);
			blim_q <= 8'd100;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ADC_FULL_SCALE:    fs_q   <= w;
				REG_ACCEL_ERROR_LIMIT: alim_q <= cfg_data[7:0];
				REG_ACCEL_MIN:         amin_q <= w;
				REG_ACCEL_MAX:         amax_q <= w;
				REG_BRAKE_HALL_MIN:    hmin_q <= w;
				REG_BRAKE_HALL_MAX:    hmax_q <= w;
				REG_BRAKE_ERROR_LIMIT: blim_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign fs        = (fs_q == '0) ? ADC_BITS'(1) : fs_q;
	assign accel_lim = alim_q;
	assign accel_min = amin_q;
	assign accel_max = amax_q;
	assign hall_min  = hmin_q;
	assign hall_max  = hmax_q;
	assign brake_lim = blim_q;

endmodule

/* src/pedal_sensor_plausibility_mapper_unit.sv */
// Top level of the pedal sensor plausibility checker and mapper.
//
//  channel | dir | payload
//  s_axis  | in  | tdata: accel_raw_a, accel_raw_b, brake_hall_raw, pressure_raw_a, pressure_raw_b
//  m_axis  | out | tdata: throttle_pct, accel_fault, brake_pedal_pct, brake_active,
//          |     |        pressure_pct, pressure_fault
//  cfg     | in  | cfg_we, cfg_index, cfg_data
//
// One sample set is taken every cycle unless a held output stalls the pipe; the bit-per-stage
// dividers form the quotients. arst_n clears valid bits and restores register defaults.
// A stall of m_axis_tready while the output stage holds a transfer freezes the whole
// pipeline and drops s_axis_tready in the same cycle; an empty output stage never stalls.
`timescale 1ns / 1ps
module pedal_sensor_plausibility_mapper_unit
	import pspm_pkg::*;
#(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// accel_raw_a, accel_raw_b, brake_hall_raw, pressure_raw_a, pressure_raw_b, zero pad
	input  logic [((5*ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// throttle_pct[6:0], accel_fault, brake_pedal_pct, brake_active, pressure_pct,
	// pressure_fault
	output logic [23:0]           m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int B   = ADC_BITS;
	localparam int NW  = B + 10;          // raw * 1000 fits here
	localparam int LAT = 2 + NW;          // registered stages in total

	logic [B-1:0] fs, amin, amax, hmin, hmax;
	logic [7:0]   alim, blim;

	pspm_cfg #(.ADC_BITS(B)) u_cfg (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.fs, .accel_lim(alim), .accel_min(amin), .accel_max(amax),
		.hall_min(hmin), .hall_max(hmax), .brake_lim(blim)
	);

	// Pipeline control: the whole pipe moves unless the output is held.
	logic [LAT-1:0] vld_q;
	stage_ctl_t     ctl;
	assign ctl.valid   = vld_q[LAT-1];
	assign ctl.advance = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = ctl.advance;
	assign m_axis_tvalid = ctl.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (ctl.advance) vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
	end

	// Stage 1: clamp and form numerators.
	logic [B-1:0] a1, a2, hl, p1, p2;
	assign a1 = s_axis_tdata[B-1:0];
	assign a2 = s_axis_tdata[2*B-1:B];
	assign hl = s_axis_tdata[3*B-1:2*B];
	assign p1 = s_axis_tdata[4*B-1:3*B];
	assign p2 = s_axis_tdata[5*B-1:4*B];

	function automatic logic [NW-1:0] clamp_num(input logic [B-1:0] r, lo, hi);
		logic [B-1:0] v;
		v = (r < lo) ? lo : ((r > hi) ? hi : r);
		return (hi <= lo) ? '0 : NW'(v - lo) * NW'(PERCENT) + NW'((hi - lo) >> 1);
	endfunction

	logic [NW-1:0] na1_s1, na2_s1, np1_s1, np2_s1, nth_s1, nbr_s1, npp_s1;
	logic [B-1:0]  dth_s1, dbr_s1;
	logic          p1sat_s1, thz_s1, brz_s1;
	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			na1_s1 <= NW'(a1) * NW'(PER_MILLE);
			na2_s1 <= NW'(a2) * NW'(PER_MILLE);
			np1_s1 <= NW'(p1) * NW'(PER_MILLE);
			np2_s1 <= NW'(p2) * NW'(PER_MILLE);
			nth_s1 <= clamp_num(a2, amin, amax);
			nbr_s1 <= clamp_num(hl, hmin, hmax);
			dth_s1 <= amax - amin;
			dbr_s1 <= hmax - hmin;
			thz_s1 <= amax <= amin;
			brz_s1 <= hmax <= hmin;
			npp_s1 <= NW'(p1) * NW'(PERCENT) + NW'(fs >> 1);
			p1sat_s1 <= p1 >= fs;
		end
	end

	// Dividers, one quotient bit per stage.
	logic [NW-1:0] qa1, qa2, qp1, qp2, qth, qbr, qpp;
	logic [B-1:0]  fs_s1;
	always_ff @(posedge clk) if (ctl.advance) fs_s1 <= fs;
	logic [B-1:0] dth_safe, dbr_safe;
	assign dth_safe = thz_s1 ? B'(1) : dth_s1;
	assign dbr_safe = brz_s1 ? B'(1) : dbr_s1;

	pspm_div #(.NUM_W(NW), .DEN_W(B)) u_da1 (.clk, .en(ctl.advance), .num(na1_s1), .den(fs_s1), .quo(qa1));
	pspm_div #(.NUM_W(NW), .DEN_W(B)) u_da2 (.clk, .en(ctl.advance), .num(na2_s1), .den(fs_s1), .quo(qa2));
	pspm_div #(.NUM_W(NW), .DEN_W(B)) u_dp1 (.clk, .en(ctl.advance), .num(np1_s1), .den(fs_s1), .quo(qp1));
	pspm_div #(.NUM_W(NW), .DEN_W(B)) u_dp2 (.clk, .en(ctl.advance), .num(np2_s1), .den(fs_s1), .quo(qp2));
	pspm_div #(.NUM_W(NW), .DEN_W(B)) u_dth (.clk, .en(ctl.advance), .num(nth_s1), .den(dth_safe), .quo(qth));
	pspm_div #(.NUM_W(NW), .DEN_W(B)) u_dbr (.clk, .en(ctl.advance), .num(nbr_s1), .den(dbr_safe), .quo(qbr));
	pspm_div #(.NUM_W(NW), .DEN_W(B)) u_dpp (.clk, .en(ctl.advance), .num(npp_s1), .den(fs_s1), .quo(qpp));

	// Saturation flag rides alongside the dividers.
	logic [NW-1:0] sat_dly_q;
	always_ff @(posedge clk) if (ctl.advance) sat_dly_q <= {sat_dly_q[NW-2:0], p1sat_s1};

	// Final stage: compare and assemble.
	logic [NW:0] ad, pd;
	logic [NW-1:0] half2;
	logic        af, pf, ba;
	logic [6:0]  brp, thr, ppc;
	assign half2 = qa2 >> 1;
	assign ad  = (half2 >= qa1) ? (NW+1)'(half2 - qa1) : (NW+1)'(qa1 - half2);
	assign pd  = (qp1 >= qp2) ? (NW+1)'(qp1 - qp2) : (NW+1)'(qp2 - qp1);
	assign af  = ad >= (NW+1)'(alim);
	assign pf  = pd > (NW+1)'(blim);
	assign brp = qbr[6:0];
	assign ba  = brp != '0;
	assign thr = (af || ba) ? 7'd0 : qth[6:0];
	assign ppc = sat_dly_q[NW-1] ? 7'(PERCENT) : qpp[6:0];

	logic [23:0] out_s3;
	always_ff @(posedge clk) begin
		if (ctl.advance) out_s3 <= {pf, ppc, ba, brp, af, thr};
	end
	assign m_axis_tdata = out_s3;

	a_thr_zero_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[7] || m_axis_tdata[15]) |-> m_axis_tdata[6:0] == 7'd0)
		else $error("throttle nonzero with fault or brake");
	a_brake_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15] == (m_axis_tdata[14:8] != 7'd0))
		else $error("brake flag mismatch");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");

endmodule

/* tb/pedal_sensor_plausibility_mapper_unit_test.sv */
// Self-checking testbench for the pedal sensor plausibility checker and mapper.
`timescale 1ns / 1ps
module pedal_sensor_plausibility_mapper_unit_test;
	import pspm_pkg::*;

	localparam int AB = 12;
	localparam int IN_W = ((5*AB+7)/8)*8;
	localparam int LATENCY = 2 + AB + 10;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [AB-1:0] pres_b;
		logic [AB-1:0] pres_a;
		logic [AB-1:0] hall;
		logic [AB-1:0] acc_b;
		logic [AB-1:0] acc_a;
	} sample_t;

	typedef struct packed {
		logic       pres_fault;
		logic [6:0] pres_pct;
		logic       brake_on;
		logic [6:0] brake_pct;
		logic       acc_fault;
		logic [6:0] throttle;
	} pedal_out_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [23:0] m_axis_tdata;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pedal_sensor_plausibility_mapper_unit dut (.*);

	// Shadow copy of the configuration registers.
	int unsigned full_scale_r = 4095, acc_limit_r = 100, acc_min_r = 0, acc_max_r = 4095;
	int unsigned hall_min_r = 0, hall_max_r = 4095, pres_limit_r = 100;

	sample_t pending_samples[$];
	pedal_out_t expected_outputs[$];
	int errors = 0;
	int accepted_in = 0;
	bit stim_done = 0;
	bit quiet_in = 0, quiet_out = 0;
	int hold_off = 0;
	bit hold_req = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int unsigned clamp_pct(int unsigned raw, int unsigned lo, int unsigned hi);
		int unsigned v;
		v = raw;
		if (v < lo) v = lo;
		else if (v > hi) v = hi;
		if (hi <= lo) return 0;
		return ((v - lo) * 100 + (hi - lo) / 2) / (hi - lo);
	endfunction

	function automatic pedal_out_t map_pedals(sample_t s);
		pedal_out_t r;
		int unsigned fs;
		longint d;
		fs = (full_scale_r == 0) ? 1 : full_scale_r;
		d = longint'((s.acc_b * 1000 / fs) / 2) - longint'(s.acc_a * 1000 / fs);
		if (d < 0) d = -d;
		r.acc_fault = d >= acc_limit_r;
		d = longint'(s.pres_a * 1000 / fs) - longint'(s.pres_b * 1000 / fs);
		if (d < 0) d = -d;
		r.pres_fault = d > pres_limit_r;
		r.brake_pct = 7'(clamp_pct(s.hall, hall_min_r, hall_max_r));
		r.brake_on = r.brake_pct != 0;
		r.throttle = (r.acc_fault || r.brake_on) ? 7'd0 :
			7'(clamp_pct(s.acc_b, acc_min_r, acc_max_r));
		r.pres_pct = (s.pres_a >= fs) ? 7'd100 : 7'((s.pres_a * 100 + fs / 2) / fs);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	// Driver: the prediction is made at the transfer, under the current settings.
	// An offered item stays on the bus until it is taken.
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			expected_outputs.push_back(map_pedals(sample_t'(s_axis_tdata[5*AB-1:0])));
			accepted_in++;
			void'(pending_samples.pop_front());
		end
		if (s_axis_tvalid && !s_axis_tready) begin
			s_axis_tvalid <= 1;
		end else if (arst_n && pending_samples.size() > 0
				&& (quiet_in || $urandom_range(99) >= 8)) begin
			s_axis_tvalid <= 1;
			s_axis_tdata <= IN_W'(pending_samples[0]);
		end else begin
			s_axis_tvalid <= 0;
		end
	end

	// Monitor and receiver.
	always @(posedge clk) begin
		pedal_out_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = pedal_out_t'(m_axis_tdata);
			if (expected_outputs.size() == 0) begin
				report_mismatch("unexpected transfer", 1, 0);
			end else begin
				want = expected_outputs.pop_front();
				if (got.throttle !== want.throttle)
					report_mismatch("throttle_pct", got.throttle, want.throttle);
				if (got.acc_fault !== want.acc_fault)
					report_mismatch("accel_fault", got.acc_fault, want.acc_fault);
				if (got.brake_pct !== want.brake_pct)
					report_mismatch("brake_pedal_pct", got.brake_pct, want.brake_pct);
				if (got.brake_on !== want.brake_on)
					report_mismatch("brake_active", got.brake_on, want.brake_on);
				if (got.pres_pct !== want.pres_pct)
					report_mismatch("pressure_pct", got.pres_pct, want.pres_pct);
				if (got.pres_fault !== want.pres_fault)
					report_mismatch("pressure_fault", got.pres_fault, want.pres_fault);
			end
		end
		if (hold_req && hold_off == 0) begin
			hold_off = 300;
		end
		if (hold_off > 0) begin
			hold_off--;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= arst_n && (quiet_out || $urandom_range(99) >= 8);
		end
	end

	// Watchdog on cycles without any transfer.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT && !stim_done) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_ADC_FULL_SCALE:    full_scale_r = val & 12'hFFF;
			REG_ACCEL_ERROR_LIMIT: acc_limit_r = val & 8'hFF;
			REG_ACCEL_MIN:         acc_min_r = val & 12'hFFF;
			REG_ACCEL_MAX:         acc_max_r = val & 12'hFFF;
			REG_BRAKE_HALL_MIN:    hall_min_r = val & 12'hFFF;
			REG_BRAKE_HALL_MAX:    hall_max_r = val & 12'hFFF;
			REG_BRAKE_ERROR_LIMIT: pres_limit_r = val & 8'hFF;
			default: ;
		endcase
	endtask

	task automatic drain_pipeline();
		while (pending_samples.size() != 0 || expected_outputs.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic int unsigned rnd_adc();
		case ($urandom_range(5))
			0: return 0;
			1: return 4095;
			2: return full_scale_r;
			default: return $urandom_range(4095);
		endcase
	endfunction

	// A consistent sample has acc_b near twice acc_a so the check usually passes.
	task automatic queue_random(int n);
		sample_t s;
		int unsigned a;
		repeat (n) begin
			a = $urandom_range(2047);
			s.acc_a = 12'(a);
			s.acc_b = ($urandom_range(3) == 0) ? 12'($urandom) : 12'(2 * a + $urandom_range(8));
			s.hall = ($urandom_range(2) == 0) ? 12'(hall_min_r) : 12'(rnd_adc());
			s.pres_a = 12'(rnd_adc());
			s.pres_b = ($urandom_range(2) == 0) ? 12'(s.pres_a + $urandom_range(300))
				: 12'(rnd_adc());
			pending_samples.push_back(s);
		end
	endtask

	task automatic queue_sample(int unsigned a, b, h, p, q);
		pending_samples.push_back({12'(q), 12'(p), 12'(h), 12'(b), 12'(a)});
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		// Directed: field extremes, brake pressed, limits, saturation.
		queue_sample(0, 0, 0, 0, 0);
		queue_sample(4095, 4095, 4095, 4095, 4095);
		queue_sample(1000, 2000, 0, 2000, 2000);
		queue_sample(1000, 2000, 100, 2000, 2000);
		queue_sample(0, 4095, 0, 0, 4095);
		queue_sample(2047, 4094, 0, 4095, 0);
		queue_sample(2730, 1365, 2730, 1365, 2730);
		queue_sample(1, 2, 1, 4094, 3685);
		drain_pipeline();

		// Zero full scale, zero accel limit, empty and inverted ranges.
		write_reg(REG_ADC_FULL_SCALE, 0);
		write_reg(REG_ACCEL_ERROR_LIMIT, 0);
		write_reg(REG_ACCEL_MIN, 3000);
		write_reg(REG_ACCEL_MAX, 1000);
		write_reg(REG_BRAKE_HALL_MIN, 2000);
		write_reg(REG_BRAKE_HALL_MAX, 2000);
		write_reg(REG_BRAKE_ERROR_LIMIT, 0);
		queue_sample(0, 0, 0, 0, 0);
		queue_sample(1, 1, 2500, 1, 0);
		queue_sample(4095, 2000, 1500, 0, 1);
		drain_pipeline();
		write_reg(cfg_reg_t'(3'd7), 5);

		write_reg(REG_ADC_FULL_SCALE, 4095);
		write_reg(REG_ACCEL_ERROR_LIMIT, 255);
		write_reg(REG_ACCEL_MIN, 200);
		write_reg(REG_ACCEL_MAX, 3900);
		write_reg(REG_BRAKE_HALL_MIN, 300);
		write_reg(REG_BRAKE_HALL_MAX, 3800);
		write_reg(REG_BRAKE_ERROR_LIMIT, 255);
		queue_sample(100, 150, 299, 4095, 0);
		queue_sample(1000, 4095, 4000, 2048, 2048);
		queue_sample(2000, 3950, 310, 1, 4095);
		drain_pipeline();

		// Random phases under several settings; one adds a held stall of m_axis_tready to the random backpressure.
		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				write_reg(REG_ADC_FULL_SCALE, (ph == 5) ? 1 : $urandom_range(4095));
				write_reg(REG_ACCEL_ERROR_LIMIT, $urandom_range(255));
				write_reg(REG_ACCEL_MIN, $urandom_range(1500));
				write_reg(REG_ACCEL_MAX, $urandom_range(4095, 1000));
				write_reg(REG_BRAKE_HALL_MIN, $urandom_range(1500));
				write_reg(REG_BRAKE_HALL_MAX, $urandom_range(4095, 1000));
				write_reg(REG_BRAKE_ERROR_LIMIT, $urandom_range(255));
			end
			quiet_in = (ph == 2);
			quiet_out = (ph == 2);
			queue_random(330);
			if (ph == 3) begin
				repeat (20) @(posedge clk);
				hold_req <= 1;
				@(posedge clk);
				hold_req <= 0;
			end
			drain_pipeline();
		end
		stim_done = 1;
		if (errors == 0 && expected_outputs.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
